/* src/soe_pkg.sv */
// shared types and constants of the set operation engine
package soe_pkg;

  localparam int MAX_ELEMS = 8;
  localparam int IDX_W     = $clog2(MAX_ELEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int ADDR_W    = IDX_W + 1;
  localparam int VAL_W     = 32;

  // input command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_PUSH_A = 2'd1;
  localparam logic [1:0] CMD_PUSH_B = 2'd2;
  localparam logic [1:0] CMD_RUN    = 2'd3;

  // set operation codes
  localparam logic [2:0] OP_UNION  = 3'd0;
  localparam logic [2:0] OP_INTER  = 3'd1;
  localparam logic [2:0] OP_AMINB  = 3'd2;
  localparam logic [2:0] OP_BMINA  = 3'd3;
  localparam logic [2:0] OP_SYMDIF = 3'd4;
  localparam logic [2:0] OP_COMPA  = 3'd5;
  localparam logic [2:0] OP_COMPB  = 3'd6;

  // element store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } soe_wr_t;

endpackage

/* src/soe_lists.sv */
// element store holding list a (low half) and list b (high half)
module soe_lists (
  input  logic                          clk,
  input  soe_pkg::soe_wr_t              wr,
  input  logic [soe_pkg::ADDR_W-1:0]    rd_x_addr,
  input  logic [soe_pkg::ADDR_W-1:0]    rd_y_addr,
  output logic [soe_pkg::VAL_W-1:0]     rd_x_data,
  output logic [soe_pkg::VAL_W-1:0]     rd_y_data
);
  import soe_pkg::*;

  logic [VAL_W-1:0] mem [2*MAX_ELEMS];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_x_data <= mem[rd_x_addr];
    rd_y_data <= mem[rd_y_addr];
  end

endmodule

/* src/soe_cmp.sv */
// shared ieee single equality compare unit
module soe_cmp (
  input  logic [soe_pkg::VAL_W-1:0] x,
  input  logic [soe_pkg::VAL_W-1:0] y,
  output logic                      eq
);
  import soe_pkg::*;

  logic x_nan;
  logic y_nan;
  logic both_zero;

  // nan never matches, signed zeros match
  always_comb begin
    x_nan     = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    y_nan     = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    both_zero = ((x[30:0] | y[30:0]) == 31'd0);
    eq        = !x_nan && !y_nan && (both_zero || (x == y));
  end

endmodule

/* src/set_operation_engine.sv */
// set operation engine: loads lists a and b, emits a set result run per run command
// a run scans list entries for each element and compares them on the shared compare unit
// (registered store read, then compare), then closes the run; output stalls can hold it
// throughput: one item at a time, input not ready during a run
// reset: synchronous active low, empties both lists, clears lost flag and set_op
module set_operation_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_value[31:0]
  output logic [1:0]  out_tuser,  // out_valid[0], lost_elements[1]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data    // set_op[2:0]
);
  import soe_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ELEM, S_RD, S_CMP, S_FIN} state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        set_op_r, set_op_nxt;
  logic [CNT_W-1:0]  cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic              drop_r, drop_nxt;
  logic              phase_r, phase_nxt;
  logic [IDX_W-1:0]  e_r, e_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;
  logic              none_r, none_nxt;
  logic              hit_r, hit_nxt;
  logic              p_valid_r, p_valid_nxt;
  logic [VAL_W-1:0]  p_value_r, p_value_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic              out_flag_r, out_flag_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_lost_r, out_lost_nxt;

  soe_wr_t           wr;
  logic [VAL_W-1:0]  x_data, y_data;
  logic              cmp_eq;

  logic              a_act, b_act, scan_a, per_match, slot_ok;
  logic [CNT_W-1:0]  lim_b, cur_cnt;
  logic [ADDR_W-1:0] first_j, next_j;
  logic              first_none, elem_end, eq, emit_now;

  soe_lists u_lists (
    .clk       (clk),
    .wr        (wr),
    .rd_x_addr ({phase_r, e_r}),
    .rd_y_addr (j_r),
    .rd_x_data (x_data),
    .rd_y_data (y_data)
  );

  soe_cmp u_cmp (
    .x  (x_data),
    .y  (y_data),
    .eq (cmp_eq)
  );

  // per-operation scan plan for the current phase
  always_comb begin
    a_act = (set_op_r != OP_BMINA) && (set_op_r <= OP_COMPB);
    b_act = (set_op_r == OP_UNION) || (set_op_r == OP_BMINA) || (set_op_r == OP_SYMDIF)
         || (set_op_r == OP_COMPA) || (set_op_r == OP_COMPB);
    per_match = !phase_r && (set_op_r == OP_INTER);
    if (phase_r) begin
      scan_a = (set_op_r != OP_COMPB);
      if (set_op_r == OP_BMINA) begin
        lim_b = '0;
      end else if (set_op_r == OP_COMPB) begin
        lim_b = cnt_b_r;
      end else begin
        lim_b = {1'b0, e_r};
      end
      cur_cnt = cnt_b_r;
    end else begin
      scan_a = (set_op_r == OP_COMPA);
      lim_b  = ((set_op_r == OP_INTER) || (set_op_r == OP_AMINB) || (set_op_r == OP_SYMDIF)
             || (set_op_r == OP_COMPB)) ? cnt_b_r : '0;
      cur_cnt = cnt_a_r;
    end
  end

  // scan pointer: list a entries first, then the allowed prefix of list b
  always_comb begin
    first_none = 1'b0;
    if (scan_a && (cnt_a_r != '0)) begin
      first_j = '0;
    end else if (lim_b != '0) begin
      first_j = {1'b1, {IDX_W{1'b0}}};
    end else begin
      first_j    = '0;
      first_none = 1'b1;
    end
    next_j   = j_r + 1'b1;
    elem_end = 1'b0;
    if (none_r) begin
      elem_end = 1'b1;
    end else if (!j_r[ADDR_W-1]) begin
      if (({1'b0, j_r[IDX_W-1:0]} + 1'b1) >= cnt_a_r) begin
        if (lim_b != '0) begin
          next_j = {1'b1, {IDX_W{1'b0}}};
        end else begin
          elem_end = 1'b1;
        end
      end
    end else if (({1'b0, j_r[IDX_W-1:0]} + 1'b1) >= lim_b) begin
      elem_end = 1'b1;
    end
  end

  // sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    set_op_nxt    = set_op_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    drop_nxt      = drop_r;
    phase_nxt     = phase_r;
    e_nxt         = e_r;
    j_nxt         = j_r;
    none_nxt      = none_r;
    hit_nxt       = hit_r;
    p_valid_nxt   = p_valid_r;
    p_value_nxt   = p_value_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    out_flag_nxt  = out_flag_r;
    out_last_nxt  = out_last_r;
    out_lost_nxt  = out_lost_r;
    wr            = '0;
    slot_ok       = !out_valid_r || out_tready;
    eq            = !none_r && cmp_eq;
    emit_now      = per_match ? eq : (elem_end && !(hit_r || eq));

    if (cfg_valid) begin
      set_op_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            CMD_CLEAR: begin
              cnt_a_nxt = '0;
              cnt_b_nxt = '0;
              drop_nxt  = 1'b0;
            end
            CMD_PUSH_A: begin
              if (cnt_a_r != CNT_W'(MAX_ELEMS)) begin
                wr.en     = 1'b1;
                wr.addr   = {1'b0, cnt_a_r[IDX_W-1:0]};
                wr.data   = in_tdata;
                cnt_a_nxt = cnt_a_r + 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            CMD_PUSH_B: begin
              if (cnt_b_r != CNT_W'(MAX_ELEMS)) begin
                wr.en     = 1'b1;
                wr.addr   = {1'b1, cnt_b_r[IDX_W-1:0]};
                wr.data   = in_tdata;
                cnt_b_nxt = cnt_b_r + 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            default: begin
              p_valid_nxt = 1'b0;
              e_nxt       = '0;
              if (a_act && (cnt_a_r != '0)) begin
                phase_nxt = 1'b0;
                state_nxt = S_ELEM;
              end else if (b_act && (cnt_b_r != '0)) begin
                phase_nxt = 1'b1;
                state_nxt = S_ELEM;
              end else begin
                state_nxt = S_FIN;
              end
            end
          endcase
        end
      end
      S_ELEM: begin
        j_nxt     = first_j;
        none_nxt  = first_none;
        hit_nxt   = 1'b0;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!(emit_now && p_valid_r && !slot_ok)) begin
          if (emit_now) begin
            if (p_valid_r) begin
              out_valid_nxt = 1'b1;
              out_value_nxt = p_value_r;
              out_flag_nxt  = 1'b1;
              out_last_nxt  = 1'b0;
              out_lost_nxt  = drop_r;
            end
            p_valid_nxt = 1'b1;
            p_value_nxt = x_data;
          end
          hit_nxt = hit_r || eq;
          if (!elem_end) begin
            j_nxt     = next_j;
            state_nxt = S_RD;
          end else if (({1'b0, e_r} + 1'b1) < cur_cnt) begin
            e_nxt     = e_r + 1'b1;
            state_nxt = S_ELEM;
          end else if (!phase_r && b_act && (cnt_b_r != '0)) begin
            phase_nxt = 1'b1;
            e_nxt     = '0;
            state_nxt = S_ELEM;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (slot_ok) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = p_valid_r ? p_value_r : '0;
          out_flag_nxt  = p_valid_r;
          out_last_nxt  = 1'b1;
          out_lost_nxt  = drop_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      set_op_r    <= OP_UNION;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      drop_r      <= 1'b0;
      phase_r     <= 1'b0;
      e_r         <= '0;
      j_r         <= '0;
      none_r      <= 1'b0;
      hit_r       <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      set_op_r    <= set_op_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      drop_r      <= drop_nxt;
      phase_r     <= phase_nxt;
      e_r         <= e_nxt;
      j_r         <= j_nxt;
      none_r      <= none_nxt;
      hit_r       <= hit_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_value_r   <= p_value_nxt;
    out_value_r <= out_value_nxt;
    out_flag_r  <= out_flag_nxt;
    out_last_r  <= out_last_nxt;
    out_lost_r  <= out_lost_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_lost_r, out_flag_r};
  assign out_tlast  = out_last_r;

endmodule

/* src/soe_checker.sv */
// port-level checks of the set operation engine, bound to the top level
module soe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import soe_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // empty marker closes the run and carries zero
  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == 32'd0))
    else $error("empty marker malformed");

  // the input side stops only after a run command
  a_busy_on_run: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid) && ($past(in_tuser) == CMD_RUN))
    else $error("input stalled without a run command");

  // no result word straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result word right after reset");

endmodule

bind set_operation_engine soe_checker u_soe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
